// ----- sv/afpe_pkg.sv -----
// Shared constants for the angle filter and PWM encoder block.
// Holds parameter defaults, gain format and configuration register indexes.
// Has no dependencies.
package afpe_pkg;

	localparam int INIT_UNITS_DEF    = 128;
	localparam int ANGLE_BITS_DEF    = 12;
	localparam int ERROR_UNITS_DEF   = 127;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int GAIN_BITS  = 17;
	localparam int GAIN_SHIFT = 16;
	localparam logic [GAIN_BITS-1:0] GAIN_ONE   = 17'h10000;
	localparam logic [GAIN_BITS-1:0] GAIN_RESET = 17'd16384;

	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = GAIN_BITS;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_GAIN     = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MOUNTING_OFFSET = 1'd1;

endpackage

// ----- sv/afpe_filter.sv -----
// Circular low-pass angle filter with first-sample load and modular wrap.
// Uses afpe_pkg for the gain format.
module afpe_filter #(
	parameter int ANGLE_BITS    = afpe_pkg::ANGLE_BITS_DEF,
	parameter int FRACTION_BITS = afpe_pkg::FRACTION_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           sample_valid,
	input  logic [ANGLE_BITS-1:0]          angle_sample,
	input  logic [ANGLE_BITS-1:0]          mounting_offset,
	input  logic [afpe_pkg::GAIN_BITS-1:0] filter_gain,
	output logic [ANGLE_BITS-1:0]          smoothed_angle
);
	import afpe_pkg::*;

	localparam int FIX_BITS  = ANGLE_BITS + FRACTION_BITS;
	localparam int PROD_BITS = FIX_BITS + GAIN_BITS;
	localparam logic [FIX_BITS-1:0] FIX_HALF = FIX_BITS'(1) << (FIX_BITS - 1);

	logic [FIX_BITS-1:0]   filter_q;
	logic                  awaiting_first_q;
	logic [ANGLE_BITS-1:0] shifted;
	logic [FIX_BITS-1:0]   target;
	logic [FIX_BITS-1:0]   diff;
	logic [FIX_BITS-1:0]   mag;
	logic [FIX_BITS-1:0]   step;
	logic [FIX_BITS-1:0]   filter_next;
	logic [FIX_BITS-1:0]   filter_now;
	logic [GAIN_BITS-1:0]  gain_sat;
	logic [PROD_BITS-1:0]  prod;
	logic                  neg;

	always_comb begin
		shifted  = angle_sample + mounting_offset;
		target   = {shifted, {FRACTION_BITS{1'b0}}};
		diff     = target - filter_q;
		neg      = (diff > FIX_HALF) || ((diff == FIX_HALF) && (target < filter_q));
		mag      = neg ? (~diff + FIX_BITS'(1)) : diff;
		gain_sat = (filter_gain > GAIN_ONE) ? GAIN_ONE : filter_gain;
		prod     = PROD_BITS'(mag) * PROD_BITS'(gain_sat)
			+ (neg ? PROD_BITS'(GAIN_ONE - GAIN_BITS'(1)) : PROD_BITS'(0));
		step     = prod[GAIN_SHIFT +: FIX_BITS];
		if (awaiting_first_q) begin
			filter_next = target;
		end else if (neg) begin
			filter_next = filter_q - step;
		end else begin
			filter_next = filter_q + step;
		end
		filter_now     = sample_valid ? filter_next : filter_q;
		smoothed_angle = filter_now[FIX_BITS-1 -: ANGLE_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q         <= '0;
			awaiting_first_q <= 1'b1;
		end else if (en && sample_valid) begin
			filter_q         <= filter_next;
			awaiting_first_q <= 1'b0;
		end
	end

endmodule

// ----- sv/afpe_frame.sv -----
// PWM frame counter, per-frame angle latch and pin level.
// Uses afpe_pkg for parameter defaults.
module afpe_frame #(
	parameter int INIT_UNITS  = afpe_pkg::INIT_UNITS_DEF,
	parameter int ANGLE_BITS  = afpe_pkg::ANGLE_BITS_DEF,
	parameter int ERROR_UNITS = afpe_pkg::ERROR_UNITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [ANGLE_BITS-1:0] smoothed_angle,
	input  logic                  magnet_lost,
	output logic                  pwm_level,
	output logic                  frame_begins,
	output logic [ANGLE_BITS-1:0] latched_angle
);
	import afpe_pkg::*;

	localparam int FRAME_UNITS = INIT_UNITS + (1 << ANGLE_BITS) + ERROR_UNITS;
	localparam int POS_BITS    = $clog2(FRAME_UNITS + 1);

	logic [POS_BITS-1:0]   pos_q;
	logic [ANGLE_BITS-1:0] frame_q;
	logic [POS_BITS-1:0]   pos;

	always_comb begin
		frame_begins  = (pos_q >= POS_BITS'(FRAME_UNITS));
		pos           = frame_begins ? '0 : pos_q;
		latched_angle = frame_begins ? smoothed_angle : frame_q;
		pwm_level     = !magnet_lost
			&& (pos < (POS_BITS'(INIT_UNITS) + POS_BITS'(latched_angle)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			frame_q <= '0;
		end else if (en) begin
			pos_q   <= pos + POS_BITS'(1);
			frame_q <= latched_angle;
		end
	end

endmodule

// ----- sv/angle_filter_pwm_encoder_top.sv -----
// Top level of the angle filter and PWM encoder: request registers, config registers,
// result register. Depends on afpe_pkg, afpe_filter and afpe_frame.

// Each request is one PWM unit tick and yields one result. A request is taken
// into an input register, passes the filter (offset add, circular difference,
// one gain multiply, modular add) and the frame counter combinationally, and
// lands in the result register, so one request per cycle is sustained while the
// result is not stalled. A new request is refused only while both registers are
// full and the result is stalled. The frame is INIT_UNITS + 2^ANGLE_BITS +
// ERROR_UNITS units long; the first frame after reset encodes angle zero.
module angle_filter_pwm_encoder_top #(
	parameter int INIT_UNITS    = afpe_pkg::INIT_UNITS_DEF,
	parameter int ANGLE_BITS    = afpe_pkg::ANGLE_BITS_DEF,
	parameter int ERROR_UNITS   = afpe_pkg::ERROR_UNITS_DEF,
	parameter int FRACTION_BITS = afpe_pkg::FRACTION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [afpe_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [afpe_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               sample_valid,
	input  logic [ANGLE_BITS-1:0]              angle_sample,
	input  logic                               magnet_lost,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               pwm_level,
	output logic                               frame_begins,
	output logic [ANGLE_BITS-1:0]              latched_angle,
	output logic [ANGLE_BITS-1:0]              smoothed_angle
);
	import afpe_pkg::*;

	logic [GAIN_BITS-1:0]  filter_gain_q;
	logic [ANGLE_BITS-1:0] mounting_offset_q;

	logic                  valid_s1;
	logic                  sample_valid_s1;
	logic [ANGLE_BITS-1:0] angle_sample_s1;
	logic                  magnet_lost_s1;

	logic                  valid_s2;
	logic                  pwm_level_s2;
	logic                  frame_begins_s2;
	logic [ANGLE_BITS-1:0] latched_angle_s2;
	logic [ANGLE_BITS-1:0] smoothed_angle_s2;

	logic                  advance;
	logic                  load_s1;
	logic [ANGLE_BITS-1:0] smooth;
	logic                  level;
	logic                  begins;
	logic [ANGLE_BITS-1:0] latched;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign load_s1  = !valid_s1 || advance;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_gain_q     <= GAIN_RESET;
			mounting_offset_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FILTER_GAIN: begin
					filter_gain_q <= cfg_wdata[GAIN_BITS-1:0];
				end
				CFG_MOUNTING_OFFSET: begin
					mounting_offset_q <= cfg_wdata[ANGLE_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			sample_valid_s1 <= sample_valid;
			angle_sample_s1 <= angle_sample;
			magnet_lost_s1  <= magnet_lost;
		end
	end

	afpe_filter #(
		.ANGLE_BITS    (ANGLE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_filter (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (advance),
		.sample_valid    (sample_valid_s1),
		.angle_sample    (angle_sample_s1),
		.mounting_offset (mounting_offset_q),
		.filter_gain     (filter_gain_q),
		.smoothed_angle  (smooth)
	);

	afpe_frame #(
		.INIT_UNITS  (INIT_UNITS),
		.ANGLE_BITS  (ANGLE_BITS),
		.ERROR_UNITS (ERROR_UNITS)
	) u_frame (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (advance),
		.smoothed_angle (smooth),
		.magnet_lost    (magnet_lost_s1),
		.pwm_level      (level),
		.frame_begins   (begins),
		.latched_angle  (latched)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pwm_level_s2      <= level;
			frame_begins_s2   <= begins;
			latched_angle_s2  <= latched;
			smoothed_angle_s2 <= smooth;
		end
	end

	assign out_valid      = valid_s2;
	assign pwm_level      = pwm_level_s2;
	assign frame_begins   = frame_begins_s2;
	assign latched_angle  = latched_angle_s2;
	assign smoothed_angle = smoothed_angle_s2;

endmodule

// ----- verif/afpe_tick_checker.sv -----
// Scoreboard for the angle filter and PWM encoder: watches the config port and both
// channels, predicts each tick's result and compares it field by field.
// Depends on afpe_pkg.
module afpe_tick_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [afpe_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [afpe_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic                               sample_valid,
	input  logic [afpe_pkg::ANGLE_BITS_DEF-1:0] angle_sample,
	input  logic                               magnet_lost,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic                               pwm_level,
	input  logic                               frame_begins,
	input  logic [afpe_pkg::ANGLE_BITS_DEF-1:0] latched_angle,
	input  logic [afpe_pkg::ANGLE_BITS_DEF-1:0] smoothed_angle,
	output int unsigned                        pending,
	output int unsigned                        fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import afpe_pkg::*;

	localparam int AB = ANGLE_BITS_DEF;
	localparam int FB = FRACTION_BITS_DEF;
	localparam int FIX_BITS = AB + FB;
	localparam int unsigned FRAME_UNITS = INIT_UNITS_DEF + (1 << AB) + ERROR_UNITS_DEF;
	localparam logic [FIX_BITS-1:0] FIX_HALF = {1'b1, {(FIX_BITS-1){1'b0}}};

	typedef struct packed {
		logic          level;
		logic          begins;
		logic [AB-1:0] latched;
		logic [AB-1:0] smooth;
	} tick_result_t;

	logic [GAIN_BITS-1:0] gain_reg;
	logic [AB-1:0]        offset_reg;
	int unsigned          unit_pos;
	logic [FIX_BITS-1:0]  filt;
	logic [AB-1:0]        frame_angle;
	logic                 awaiting_first;
	tick_result_t         expected_ticks[$];

	function automatic void filter_sample(input logic [AB-1:0] raw);
		logic [AB-1:0]        s;
		logic [FIX_BITS-1:0]  target;
		logic [FIX_BITS-1:0]  diff;
		logic [FIX_BITS-1:0]  mag;
		logic [GAIN_BITS-1:0] g;
		logic [63:0]          prod;
		logic                 neg;
		s = raw + offset_reg;
		target = {s, {FB{1'b0}}};
		if (awaiting_first) begin
			filt = target;
			awaiting_first = 1'b0;
		end else begin
			diff = target - filt;
			neg = (diff > FIX_HALF) || ((diff == FIX_HALF) && (target < filt));
			mag = neg ? FIX_BITS'(0) - diff : diff;
			g = (gain_reg > GAIN_ONE) ? GAIN_ONE : gain_reg;
			prod = 64'(mag) * 64'(g);
			// Negative steps round toward minus infinity, so the magnitude rounds up.
			if (neg)
				filt = filt - FIX_BITS'((prod + 64'(GAIN_ONE) - 64'd1) >> GAIN_SHIFT);
			else
				filt = filt + FIX_BITS'(prod >> GAIN_SHIFT);
		end
	endfunction

	function automatic tick_result_t predict_tick(input logic sv, input logic [AB-1:0] raw,
			input logic ml);
		tick_result_t r;
		int unsigned  posn;
		if (sv)
			filter_sample(raw);
		r.smooth = filt[FIX_BITS-1:FB];
		r.begins = 1'b0;
		posn = unit_pos;
		if (posn >= FRAME_UNITS) begin
			posn = 0;
			frame_angle = r.smooth;
			r.begins = 1'b1;
		end
		r.level = !ml && (posn < INIT_UNITS_DEF + frame_angle);
		r.latched = frame_angle;
		unit_pos = posn + 1;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= 40)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	always @(posedge clk) begin
		tick_result_t got;
		tick_result_t want;
		if (!arst_n) begin
			gain_reg = GAIN_RESET;
			offset_reg = '0;
			unit_pos = 0;
			filt = '0;
			frame_angle = '0;
			awaiting_first = 1'b1;
			expected_ticks.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_FILTER_GAIN)
					gain_reg = cfg_wdata;
				else if (cfg_index == CFG_MOUNTING_OFFSET)
					offset_reg = cfg_wdata[AB-1:0];
			end
			if (in_valid && !in_stall)
				expected_ticks.push_back(predict_tick(sample_valid, angle_sample, magnet_lost));
			if (out_valid && !out_stall) begin
				got = '{pwm_level, frame_begins, latched_angle, smoothed_angle};
				if (expected_ticks.size() == 0) begin
					report_mismatch("result with no request waiting");
				end else begin
					want = expected_ticks.pop_front();
					if (got.level !== want.level)
						report_mismatch($sformatf("pwm_level got %0b want %0b",
							got.level, want.level));
					if (got.begins !== want.begins)
						report_mismatch($sformatf("frame_begins got %0b want %0b",
							got.begins, want.begins));
					if (got.latched !== want.latched)
						report_mismatch($sformatf("latched_angle got %0d want %0d",
							got.latched, want.latched));
					if (got.smooth !== want.smooth)
						report_mismatch($sformatf("smoothed_angle got %0d want %0d",
							got.smooth, want.smooth));
				end
			end
		end
		pending <= expected_ticks.size();
	end

endmodule

// ----- verif/tb.sv -----
// Testbench top for the angle filter and PWM encoder: clock, reset, config writes,
// directed and random tick requests with random idling on both channels, and the verdict.
// Depends on afpe_pkg, angle_filter_pwm_encoder_top and afpe_tick_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import afpe_pkg::*;

	localparam int AB = ANGLE_BITS_DEF;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;
	logic                     in_valid;
	logic                     in_stall;
	logic                     sample_valid;
	logic [AB-1:0]            angle_sample;
	logic                     magnet_lost;
	logic                     out_valid;
	logic                     out_stall;
	logic                     pwm_level;
	logic                     frame_begins;
	logic [AB-1:0]            latched_angle;
	logic [AB-1:0]            smoothed_angle;
	int unsigned              pending;
	int unsigned              fail_count;

	int unsigned   send_idle_pct;
	int unsigned   recv_idle_pct;
	logic [AB-1:0] last_raw;

	angle_filter_pwm_encoder_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample_valid(sample_valid), .angle_sample(angle_sample), .magnet_lost(magnet_lost),
		.out_valid(out_valid), .out_stall(out_stall),
		.pwm_level(pwm_level), .frame_begins(frame_begins),
		.latched_angle(latched_angle), .smoothed_angle(smoothed_angle)
	);

	afpe_tick_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample_valid(sample_valid), .angle_sample(angle_sample), .magnet_lost(magnet_lost),
		.out_valid(out_valid), .out_stall(out_stall),
		.pwm_level(pwm_level), .frame_begins(frame_begins),
		.latched_angle(latched_angle), .smoothed_angle(smoothed_angle),
		.pending(pending), .fail_count(fail_count)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic send_tick(input logic sv, input logic [AB-1:0] raw, input logic ml);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_valid <= sv;
		angle_sample <= raw;
		magnet_lost <= ml;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain_results;
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_config(input logic [GAIN_BITS-1:0] gain, input logic [AB-1:0] offset);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FILTER_GAIN;
		cfg_wdata <= gain;
		@(posedge clk);
		cfg_index <= CFG_MOUNTING_OFFSET;
		cfg_wdata <= CFG_DATA_BITS'(offset);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Most requests carry no sample; samples stay near the last one, repeat it, jump at
	// random, land exactly half a turn away, or sit at either end of the range.
	task automatic run_segment(input int unsigned n_samples);
		int unsigned   gap;
		int unsigned   pick;
		logic [AB-1:0] raw;
		repeat (n_samples) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(24);
			repeat (gap)
				send_tick(1'b0, AB'($urandom), $urandom_range(99) < 8);
			pick = $urandom_range(99);
			if (pick < 35)
				raw = AB'($urandom);
			else if (pick < 75)
				raw = last_raw + AB'($urandom_range(64)) - AB'(32);
			else if (pick < 85)
				raw = last_raw ^ {1'b1, {(AB-1){1'b0}}};
			else if (pick < 92)
				raw = last_raw;
			else
				raw = $urandom_range(1) ? {AB{1'b1}} : {AB{1'b0}};
			last_raw = raw;
			send_tick(1'b1, raw, $urandom_range(99) < 8);
		end
	endtask

	initial begin
		logic [GAIN_BITS-1:0] gain;
		logic [AB-1:0]        offset;
		send_idle_pct = 6;
		recv_idle_pct = 85;
		last_raw = '0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_FILTER_GAIN;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		sample_valid <= 1'b0;
		angle_sample <= '0;
		magnet_lost <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: ticks before the first sample, the first sample, wrap at zero.
		send_tick(1'b0, 12'h000, 1'b0);
		send_tick(1'b0, 12'hABC, 1'b1);
		send_tick(1'b1, 12'hFFF, 1'b0);
		send_tick(1'b1, 12'h000, 1'b0);
		send_tick(1'b1, 12'hFFE, 1'b1);
		send_tick(1'b0, 12'h555, 1'b0);
		drain_results();

		// Unity gain snaps the filter, so both half-turn cases are hit exactly.
		write_config(GAIN_ONE, 12'hFFF);
		send_tick(1'b1, 12'h000, 1'b0);
		send_tick(1'b1, 12'h800, 1'b0);
		send_tick(1'b1, 12'h000, 1'b0);
		send_tick(1'b1, 12'h001, 1'b0);
		drain_results();

		write_config('0, 12'h800);
		send_tick(1'b1, 12'hFFF, 1'b0);
		send_tick(1'b1, 12'h7FF, 1'b1);
		drain_results();

		write_config({GAIN_BITS{1'b1}}, 12'h000);
		send_tick(1'b1, 12'h800, 1'b0);
		send_tick(1'b1, 12'h123, 1'b0);
		drain_results();

		for (int seg = 0; seg < 6; seg++) begin
			if (seg < 2) begin
				send_idle_pct = 6;
				recv_idle_pct = 85;
			end else if (seg < 4) begin
				send_idle_pct = 85;
				recv_idle_pct = 6;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (seg)
				0: begin
					gain = {GAIN_BITS{1'b1}};
					offset = AB'($urandom);
				end
				1: begin
					gain = GAIN_BITS'($urandom_range(GAIN_ONE));
					offset = '0;
				end
				2: begin
					gain = GAIN_BITS'(1);
					offset = {AB{1'b1}};
				end
				3: begin
					gain = GAIN_BITS'($urandom);
					offset = AB'($urandom);
				end
				4: begin
					gain = GAIN_ONE;
					offset = 12'h800;
				end
				default: begin
					gain = GAIN_BITS'($urandom_range(2048));
					offset = AB'($urandom);
				end
			endcase
			write_config(gain, offset);
			run_segment(19);
			drain_results();
		end

		if (fail_count == 0)
			$display("PASS angle_filter_pwm_encoder_top");
		else
			$display("FAIL angle_filter_pwm_encoder_top");
		$finish;
	end

	initial begin
		#3ms;
		$display("FAIL angle_filter_pwm_encoder_top");
		$finish;
	end

endmodule
